// ===== rtl/orl_pkg.sv =====
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types, character codes and helper functions for the object record
// loader.
// ----------------------------------------------------------------------------
package orl_pkg;

    localparam int ADDR_BITS_DEF  = 24;
    localparam int NAME_CHARS_DEF = 6;

    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] HEX_ZERO   = 8'd48;
    localparam logic [7:0] HEX_GAP    = 8'd7;
    localparam logic [7:0] HEX_NINE   = 8'd9;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REC_HEADER = 2'd0,
        REC_TEXT   = 2'd1,
        REC_SKIP   = 2'd2
    } t_rec_type;

    // Parse flags carried between the state registers and the step logic
    typedef struct packed {
        logic      header_seen;
        logic      finished;
        logic      at_start;
        t_rec_type rec_type;
        logic [1:0] sep_cnt;
        logic      nib_pend;
    } t_ctrl;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Loose hex conversion: any character maps to some nibble
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = c - HEX_ZERO;
        if (d > HEX_NINE) begin
            d = d - HEX_GAP;
        end
        return d[3:0];
    endfunction

endpackage

// ===== rtl/orl_if.sv =====
// ----------------------------------------------------------------------------
// orl_char_if / orl_rec_if
// Valid/ready channels for the character stream and the loader results.
// ----------------------------------------------------------------------------
interface orl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface orl_rec_if #(
    parameter int ADDRESS_BITS = orl_pkg::ADDR_BITS_DEF,
    parameter int NAME_CHARS   = orl_pkg::NAME_CHARS_DEF
);
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [ADDRESS_BITS-1:0]   address;
    logic [7:0]                data_byte;
    logic [NAME_CHARS*8-1:0]   program_name;
    logic [ADDRESS_BITS-1:0]   program_length;

    modport source (
        output valid, output kind, output address, output data_byte,
        output program_name, output program_length, input ready
    );
    modport sink (
        input valid, input kind, input address, input data_byte,
        input program_name, input program_length, output ready
    );
endinterface

// ===== rtl/orl_step.sv =====
// ----------------------------------------------------------------------------
// orl_step
// Next-state and result logic for one character of the object program.
// ----------------------------------------------------------------------------
module orl_step #(
    parameter int ADDRESS_BITS = orl_pkg::ADDR_BITS_DEF,
    parameter int NAME_CHARS   = orl_pkg::NAME_CHARS_DEF,
    localparam int CW          = $clog2(NAME_CHARS + 1)
) (
    input  logic [7:0]              i_char,
    input  orl_pkg::t_ctrl          i_ctrl,
    input  logic [ADDRESS_BITS-1:0] i_load_addr,
    input  logic [3:0]              i_high_nib,
    input  logic [NAME_CHARS*8-1:0] i_name,
    input  logic [CW-1:0]           i_name_cnt,
    input  logic [ADDRESS_BITS-1:0] i_start,
    input  logic [ADDRESS_BITS-1:0] i_length,
    output orl_pkg::t_ctrl          o_ctrl,
    output logic [ADDRESS_BITS-1:0] o_load_addr,
    output logic [3:0]              o_high_nib,
    output logic [NAME_CHARS*8-1:0] o_name,
    output logic [CW-1:0]           o_name_cnt,
    output logic [ADDRESS_BITS-1:0] o_start,
    output logic [ADDRESS_BITS-1:0] o_length,
    output logic                    o_res_valid,
    output orl_pkg::t_kind          o_res_kind,
    output logic [ADDRESS_BITS-1:0] o_res_addr,
    output logic [7:0]              o_res_byte
);

    logic [3:0] d;

    assign d = orl_pkg::hex_value(i_char);

    always_comb begin
        o_ctrl      = i_ctrl;
        o_load_addr = i_load_addr;
        o_high_nib  = i_high_nib;
        o_name      = i_name;
        o_name_cnt  = i_name_cnt;
        o_start     = i_start;
        o_length    = i_length;
        o_res_valid = 1'b0;
        o_res_kind  = orl_pkg::KIND_BYTE;
        o_res_addr  = '0;
        o_res_byte  = '0;

        if (i_ctrl.finished) begin
            // drop everything after the end record
        end else if (orl_pkg::is_space(i_char)) begin
            if (!i_ctrl.at_start) begin
                o_ctrl.at_start = 1'b1;
                o_ctrl.nib_pend = 1'b0;
                o_ctrl.sep_cnt  = 2'd0;
                if (i_ctrl.rec_type == orl_pkg::REC_HEADER && !i_ctrl.header_seen) begin
                    o_ctrl.header_seen = 1'b1;
                    o_res_valid        = 1'b1;
                    o_res_kind         = orl_pkg::KIND_HEADER;
                    o_res_addr         = i_start;
                end
            end
        end else if (i_ctrl.at_start) begin
            o_ctrl.at_start = 1'b0;
            o_ctrl.sep_cnt  = 2'd0;
            o_ctrl.nib_pend = 1'b0;
            if (!i_ctrl.header_seen) begin
                o_ctrl.rec_type = orl_pkg::REC_HEADER;
            end else if (i_char == orl_pkg::CHAR_T) begin
                o_ctrl.rec_type = orl_pkg::REC_TEXT;
            end else if (i_char == orl_pkg::CHAR_E) begin
                o_ctrl.finished = 1'b1;
                o_res_valid     = 1'b1;
                o_res_kind      = orl_pkg::KIND_END;
            end else begin
                o_ctrl.rec_type = orl_pkg::REC_SKIP;
            end
        end else if (i_char == orl_pkg::CHAR_CARET) begin
            if (i_ctrl.sep_cnt != 2'd3) begin
                o_ctrl.sep_cnt = i_ctrl.sep_cnt + 2'd1;
            end
            o_ctrl.nib_pend = 1'b0;
            // field 1 of a text record restarts the load address
            if (i_ctrl.rec_type == orl_pkg::REC_TEXT && o_ctrl.sep_cnt == 2'd1) begin
                o_load_addr = '0;
            end
        end else if (i_ctrl.rec_type == orl_pkg::REC_HEADER) begin
            if (i_ctrl.sep_cnt == 2'd1) begin
                if (i_name_cnt < CW'(NAME_CHARS)) begin
                    for (int k = 0; k < NAME_CHARS; k++) begin
                        if (i_name_cnt == CW'(NAME_CHARS - 1 - k)) begin
                            o_name[k*8 +: 8] = i_char;
                        end
                    end
                    o_name_cnt = i_name_cnt + CW'(1);
                end
            end else if (i_ctrl.sep_cnt == 2'd2) begin
                o_start = {i_start[ADDRESS_BITS-5:0], d};
            end else if (i_ctrl.sep_cnt == 2'd3) begin
                o_length = {i_length[ADDRESS_BITS-5:0], d};
            end
        end else if (i_ctrl.rec_type == orl_pkg::REC_TEXT) begin
            if (i_ctrl.sep_cnt == 2'd1) begin
                o_load_addr = {i_load_addr[ADDRESS_BITS-5:0], d};
            end else if (i_ctrl.sep_cnt == 2'd3) begin
                if (!i_ctrl.nib_pend) begin
                    o_high_nib      = d;
                    o_ctrl.nib_pend = 1'b1;
                end else begin
                    o_ctrl.nib_pend = 1'b0;
                    o_res_valid     = 1'b1;
                    o_res_kind      = orl_pkg::KIND_BYTE;
                    o_res_addr      = i_load_addr;
                    o_res_byte      = {i_high_nib, d};
                    o_load_addr     = i_load_addr + ADDRESS_BITS'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/object_record_loader_unit.sv =====
// ----------------------------------------------------------------------------
// object_record_loader_unit
// Absolute loader for a SIC-style object program fed one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one ASCII character per request. Whitespace ends a record,
//   '^' separates fields. The first record is the header; on its end one
//   header summary request (kind 1: name, start, length) leaves on o_out.
//   Text records ('T') give one byte write request (kind 0) per hex digit
//   pair from field 3 on. An 'E' record gives one end request (kind 2) and
//   every later character is swallowed. Other records are skipped.
// Throughput and datapath:
//   One character per cycle while o_out is not stalled. A character is
//   held in the input register, then a single pass of parse logic updates
//   the state and loads the result register, from which the result is
//   presented on o_out.
// Reset:
//   Synchronous, active low; parse state returns to "header expected",
//   the name to all spaces, both registers empty.
// Stall:
//   While o_out is stalled with a result waiting, an empty input register
//   still takes one more character; then i_in.ready drops until o_out moves.
// ----------------------------------------------------------------------------
module object_record_loader_unit #(
    parameter int ADDRESS_BITS = orl_pkg::ADDR_BITS_DEF,
    parameter int NAME_CHARS   = orl_pkg::NAME_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    orl_char_if.sink    i_in,
    orl_rec_if.source   o_out
);

    localparam int CW = $clog2(NAME_CHARS + 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;

    // parse state
    orl_pkg::t_ctrl          r_ctrl,      n_ctrl;
    logic [ADDRESS_BITS-1:0] r_load_addr, n_load_addr;
    logic [3:0]              r_high_nib,  n_high_nib;
    logic [NAME_CHARS*8-1:0] r_name,      n_name;
    logic [CW-1:0]           r_name_cnt,  n_name_cnt;
    logic [ADDRESS_BITS-1:0] r_start,     n_start;
    logic [ADDRESS_BITS-1:0] r_length,    n_length;

    // result register
    logic                    r_out_valid;
    orl_pkg::t_kind          r_out_kind;
    logic [ADDRESS_BITS-1:0] r_out_addr;
    logic [7:0]              r_out_byte;
    logic [NAME_CHARS*8-1:0] r_out_name;
    logic [ADDRESS_BITS-1:0] r_out_length;

    logic                    res_valid;
    orl_pkg::t_kind          res_kind;
    logic [ADDRESS_BITS-1:0] res_addr;
    logic [7:0]              res_byte;
    logic                    advance;
    logic                    in_take;

    // advance the parse stage whenever the result register can take a value
    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    orl_step #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .NAME_CHARS   (NAME_CHARS)
    ) u_step (
        .i_char      (r_in_char),
        .i_ctrl      (r_ctrl),
        .i_load_addr (r_load_addr),
        .i_high_nib  (r_high_nib),
        .i_name      (r_name),
        .i_name_cnt  (r_name_cnt),
        .i_start     (r_start),
        .i_length    (r_length),
        .o_ctrl      (n_ctrl),
        .o_load_addr (n_load_addr),
        .o_high_nib  (n_high_nib),
        .o_name      (n_name),
        .o_name_cnt  (n_name_cnt),
        .o_start     (n_start),
        .o_length    (n_length),
        .o_res_valid (res_valid),
        .o_res_kind  (res_kind),
        .o_res_addr  (res_addr),
        .o_res_byte  (res_byte)
    );

    // input register: hold until the parse stage consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_in.character;
        end
    end

    // parse state: update once per consumed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= '{header_seen: 1'b0, finished: 1'b0, at_start: 1'b1,
                             rec_type: orl_pkg::REC_HEADER, sep_cnt: 2'd0,
                             nib_pend: 1'b0};
            r_load_addr <= '0;
            r_high_nib  <= '0;
            r_name      <= {NAME_CHARS{orl_pkg::CHAR_SPACE}};
            r_name_cnt  <= '0;
            r_start     <= '0;
            r_length    <= '0;
        end else if (advance && r_in_valid) begin
            r_ctrl      <= n_ctrl;
            r_load_addr <= n_load_addr;
            r_high_nib  <= n_high_nib;
            r_name      <= n_name;
            r_name_cnt  <= n_name_cnt;
            r_start     <= n_start;
            r_length    <= n_length;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res_valid) begin
            r_out_kind <= res_kind;
            r_out_addr <= res_addr;
            r_out_byte <= res_byte;
            // name and length travel only with the header summary
            if (res_kind == orl_pkg::KIND_HEADER) begin
                r_out_name   <= r_name;
                r_out_length <= r_length;
            end else begin
                r_out_name   <= '0;
                r_out_length <= '0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out_kind;
    assign o_out.address        = r_out_addr;
    assign o_out.data_byte      = r_out_byte;
    assign o_out.program_name   = r_out_name;
    assign o_out.program_length = r_out_length;

endmodule
